### hdl/suffix_automaton_builder_macros.svh
// Assertion macros for the design file that checks its own logic.
`ifndef SUFFIX_AUTOMATON_BUILDER_MACROS_SVH
`define SUFFIX_AUTOMATON_BUILDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SAB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sab_pkg.sv
package sab_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int ALPHABET    = 26;
    localparam int NSTATES     = 2 * MAX_LEN;
    localparam int SW          = 11;
    localparam int SYMW        = 5;
    localparam int TR_DEPTH    = NSTATES * ALPHABET;
    localparam int TR_AW       = $clog2(TR_DEPTH);
    localparam int KW          = $clog2(ALPHABET + 1);

    typedef logic [SW-1:0]    state_idx_t;
    typedef logic [TR_AW-1:0] tr_addr_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHK,
        ST_W1_RD,
        ST_W1_CHK,
        ST_Q_LEN,
        ST_Q_CMP,
        ST_CL_LINK,
        ST_CL_LINK2,
        ST_COPY,
        ST_W2_RD,
        ST_W2_CHK,
        ST_DONE
    } sab_state_t;

    function automatic tr_addr_t row_base(input state_idx_t s);
        return TR_AW'(s * ALPHABET);
    endfunction

endpackage

### hdl/suffix_automaton_builder.sv
// Sequence: an accepted symbol is checked first; an ignored symbol, or any symbol once the
// automaton is full, is answered from that check. Otherwise a walk adds transitions until it
// runs past the root or meets a solid one; the latter may need a clone (row copy, redirects).
// Throughput: one symbol at a time; the next is taken once the result transaction has left.
// Reset: synchronous, active low. A clearing pass then zeroes the transition,
// length and link memories; no symbol is accepted until it completes.
`include "suffix_automaton_builder_macros.svh"

module suffix_automaton_builder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] symbol
    output logic        m_tvalid,
    input  logic        m_tready,
    // [10:0] new_state, [21:11] new_length, [32:22] new_link,
    // [43:33] clone_state, [54:44] used_states
    output logic [55:0] m_tdata,
    output logic        m_tuser    // [0] full_res
);

    localparam int SW = sab_pkg::SW;

    sab_pkg::sab_state_t state_reg, state_next;
    sab_pkg::tr_addr_t   clr_cnt_reg, clr_cnt_next;
    logic [sab_pkg::SYMW-1:0] sym_reg, sym_next;
    sab_pkg::state_idx_t last_reg, last_next, count_reg, count_next;
    sab_pkg::state_idx_t p_reg, p_next, np_reg, np_next, q_reg, q_next, nq_reg, nq_next;
    sab_pkg::state_idx_t lenp_reg, lenp_next, lnp_reg, lnp_next, lko_reg, lko_next;
    logic [sab_pkg::KW-1:0] k_reg, k_next;
    logic m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg, m_data_next;
    logic m_user_reg, m_user_next;

    // Memories and their ports.
    sab_pkg::state_idx_t tr_mem [sab_pkg::TR_DEPTH];
    sab_pkg::state_idx_t len_mem [sab_pkg::NSTATES];
    sab_pkg::state_idx_t lk_mem [sab_pkg::NSTATES];

    logic tr_we, len_we, lk_we;
    sab_pkg::tr_addr_t tr_waddr, tr_raddr;
    sab_pkg::state_idx_t len_waddr, len_raddr, lk_waddr, lk_raddr;
    sab_pkg::state_idx_t tr_wdata, len_wdata, lk_wdata;
    sab_pkg::state_idx_t tr_rd, len_rd, lk_rd;

    always_ff @(posedge aclk) begin
        if (tr_we) begin
            tr_mem[tr_waddr] <= tr_wdata;
        end
        tr_rd <= tr_mem[tr_raddr];
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rd <= len_mem[len_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lk_we) begin
            lk_mem[lk_waddr] <= lk_wdata;
        end
        lk_rd <= lk_mem[lk_raddr];
    end

    assign s_tready = (state_reg == sab_pkg::ST_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sab_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            last_reg    <= SW'(1);
            count_reg   <= SW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            last_reg    <= last_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg    <= sym_next;
        p_reg      <= p_next;
        np_reg     <= np_next;
        q_reg      <= q_next;
        nq_reg     <= nq_next;
        lenp_reg   <= lenp_next;
        lnp_reg    <= lnp_next;
        lko_reg    <= lko_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        sym_next     = sym_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        p_next       = p_reg;
        np_next      = np_reg;
        q_next       = q_reg;
        nq_next      = nq_reg;
        lenp_next    = lenp_reg;
        lnp_next     = lnp_reg;
        lko_next     = lko_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        tr_we = 1'b0;  tr_waddr = '0;  tr_wdata = '0;  tr_raddr = '0;
        len_we = 1'b0; len_waddr = '0; len_wdata = '0; len_raddr = '0;
        lk_we = 1'b0;  lk_waddr = '0;  lk_wdata = '0;  lk_raddr = '0;

        unique case (state_reg)
            sab_pkg::ST_CLEAR: begin
                tr_we    = 1'b1;
                tr_waddr = clr_cnt_reg;
                if (clr_cnt_reg < sab_pkg::TR_AW'(sab_pkg::NSTATES)) begin
                    len_we    = 1'b1;
                    len_waddr = SW'(clr_cnt_reg);
                    lk_we     = 1'b1;
                    lk_waddr  = SW'(clr_cnt_reg);
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == sab_pkg::TR_AW'(sab_pkg::TR_DEPTH - 1)) begin
                    state_next = sab_pkg::ST_IDLE;
                end
            end
            sab_pkg::ST_IDLE: begin
                len_raddr = last_reg;
                if (s_tvalid && s_tready) begin
                    sym_next   = s_tdata[sab_pkg::SYMW-1:0];
                    state_next = sab_pkg::ST_CHK;
                end
            end
            sab_pkg::ST_CHK: begin
                if (len_rd >= SW'(sab_pkg::MAX_LEN)
                    || count_reg >= SW'(sab_pkg::NSTATES - 2)) begin
                    m_data_next  = {1'b0, count_reg, 44'd0};
                    m_user_next  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = sab_pkg::ST_IDLE;
                end else if (sym_reg >= sab_pkg::SYMW'(sab_pkg::ALPHABET)) begin
                    m_data_next  = {1'b0, count_reg, 44'd0};
                    m_user_next  = 1'b0;
                    m_valid_next = 1'b1;
                    state_next   = sab_pkg::ST_IDLE;
                end else begin
                    np_next    = count_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    last_next  = count_reg + 1'b1;
                    len_we     = 1'b1;
                    len_waddr  = count_reg + 1'b1;
                    len_wdata  = len_rd + 1'b1;
                    lnp_next   = len_rd + 1'b1;
                    p_next     = last_reg;
                    nq_next    = '0;
                    state_next = sab_pkg::ST_W1_RD;
                end
            end
            sab_pkg::ST_W1_RD: begin
                if (p_reg == '0) begin
                    lk_we      = 1'b1;
                    lk_waddr   = np_reg;
                    lk_wdata   = SW'(1);
                    lko_next   = SW'(1);
                    state_next = sab_pkg::ST_DONE;
                end else begin
                    tr_raddr   = sab_pkg::row_base(p_reg) + sab_pkg::TR_AW'(sym_reg);
                    lk_raddr   = p_reg;
                    state_next = sab_pkg::ST_W1_CHK;
                end
            end
            sab_pkg::ST_W1_CHK: begin
                if (tr_rd == '0) begin
                    tr_we      = 1'b1;
                    tr_waddr   = sab_pkg::row_base(p_reg) + sab_pkg::TR_AW'(sym_reg);
                    tr_wdata   = np_reg;
                    p_next     = lk_rd;
                    state_next = sab_pkg::ST_W1_RD;
                end else begin
                    q_next     = tr_rd;
                    len_raddr  = p_reg;
                    state_next = sab_pkg::ST_Q_LEN;
                end
            end
            sab_pkg::ST_Q_LEN: begin
                lenp_next  = len_rd;
                len_raddr  = q_reg;
                lk_raddr   = q_reg;
                state_next = sab_pkg::ST_Q_CMP;
            end
            sab_pkg::ST_Q_CMP: begin
                if (len_rd == lenp_reg + 1'b1) begin
                    lk_we      = 1'b1;
                    lk_waddr   = np_reg;
                    lk_wdata   = q_reg;
                    lko_next   = q_reg;
                    state_next = sab_pkg::ST_DONE;
                end else begin
                    // The clone takes the shorter length and q's old link.
                    nq_next    = count_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    len_we     = 1'b1;
                    len_waddr  = count_reg + 1'b1;
                    len_wdata  = lenp_reg + 1'b1;
                    lk_we      = 1'b1;
                    lk_waddr   = count_reg + 1'b1;
                    lk_wdata   = lk_rd;
                    lko_next   = count_reg + 1'b1;
                    state_next = sab_pkg::ST_CL_LINK;
                end
            end
            sab_pkg::ST_CL_LINK: begin
                lk_we      = 1'b1;
                lk_waddr   = q_reg;
                lk_wdata   = nq_reg;
                state_next = sab_pkg::ST_CL_LINK2;
            end
            sab_pkg::ST_CL_LINK2: begin
                lk_we      = 1'b1;
                lk_waddr   = np_reg;
                lk_wdata   = nq_reg;
                k_next     = '0;
                state_next = sab_pkg::ST_COPY;
            end
            sab_pkg::ST_COPY: begin
                // Read entry k of q's row while writing entry k-1 into the clone's row.
                if (k_reg < sab_pkg::KW'(sab_pkg::ALPHABET)) begin
                    tr_raddr = sab_pkg::row_base(q_reg) + sab_pkg::TR_AW'(k_reg);
                end
                if (k_reg != '0) begin
                    tr_we    = 1'b1;
                    tr_waddr = sab_pkg::row_base(nq_reg) + sab_pkg::TR_AW'(k_reg - 1'b1);
                    tr_wdata = tr_rd;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == sab_pkg::KW'(sab_pkg::ALPHABET)) begin
                    state_next = sab_pkg::ST_W2_RD;
                end
            end
            sab_pkg::ST_W2_RD: begin
                if (p_reg == '0) begin
                    state_next = sab_pkg::ST_DONE;
                end else begin
                    tr_raddr   = sab_pkg::row_base(p_reg) + sab_pkg::TR_AW'(sym_reg);
                    lk_raddr   = p_reg;
                    state_next = sab_pkg::ST_W2_CHK;
                end
            end
            sab_pkg::ST_W2_CHK: begin
                if (tr_rd == q_reg) begin
                    tr_we      = 1'b1;
                    tr_waddr   = sab_pkg::row_base(p_reg) + sab_pkg::TR_AW'(sym_reg);
                    tr_wdata   = nq_reg;
                    p_next     = lk_rd;
                    state_next = sab_pkg::ST_W2_RD;
                end else begin
                    state_next = sab_pkg::ST_DONE;
                end
            end
            sab_pkg::ST_DONE: begin
                m_data_next  = {1'b0, count_reg, nq_reg, lko_reg, lnp_reg, np_reg};
                m_user_next  = 1'b0;
                m_valid_next = 1'b1;
                state_next   = sab_pkg::ST_IDLE;
            end
            default: begin
                state_next = sab_pkg::ST_IDLE;
            end
        endcase
    end

    `SAB_ASSERT_NOW(a_ready_excl, s_tready, !m_valid_reg, "input ready while a result waits")
    `SAB_ASSERT_NOW(a_clear_block, state_reg == sab_pkg::ST_CLEAR, !s_tready && !m_valid_reg, "activity during clearing pass")
    `SAB_ASSERT_NOW(a_full_zero, m_tvalid && m_tuser, m_tdata[43:0] == 44'd0, "ignored symbol carries state fields")
    `SAB_ASSERT_NEXT(a_accept_chk, s_tvalid && s_tready, state_reg == sab_pkg::ST_CHK, "accepted transaction not checked")

endmodule

### verif/tb_suffix_automaton_builder.sv
`timescale 1ns / 100ps

module tb_suffix_automaton_builder;

    typedef struct packed {
        logic [sab_pkg::SW-1:0] new_state;
        logic [sab_pkg::SW-1:0] new_length;
        logic [sab_pkg::SW-1:0] new_link;
        logic [sab_pkg::SW-1:0] clone_state;
        logic [sab_pkg::SW-1:0] used_states;
        logic                   full;
    } sam_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    suffix_automaton_builder u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow copy of the automaton being built.
    int unsigned sam_next [sab_pkg::NSTATES][sab_pkg::ALPHABET];
    int unsigned sam_len [sab_pkg::NSTATES];
    int unsigned sam_link [sab_pkg::NSTATES];
    int unsigned sam_last;
    int unsigned sam_count;

    logic [4:0]  symbol_queue [$];
    sam_result_t expected_results [$];
    int          error_count = 0;
    int          symbols_sent = 0;
    int          results_seen = 0;
    int          clones_seen = 0;
    int          full_seen = 0;
    bit          quiet_idle = 1'b0;
    bit          hold_sender = 1'b0;

    function automatic int unsigned clip(int unsigned s);
        return (s < sab_pkg::NSTATES) ? s : 0;
    endfunction

    function automatic sam_result_t extend_automaton(logic [4:0] sym);
        sam_result_t r;
        int unsigned p, np, q, nq;
        r = '0;
        nq = 0;
        r.used_states = sam_count[sab_pkg::SW-1:0];
        if (sam_len[clip(sam_last)] >= sab_pkg::MAX_LEN || sam_count + 2 >= sab_pkg::NSTATES)
        begin
            r.full = 1'b1;
            return r;
        end
        if (sym >= sab_pkg::ALPHABET)
            return r;
        p = clip(sam_last);
        sam_count++;
        np = sam_count;
        sam_last = np;
        sam_len[np] = sam_len[p] + 1;
        while (p != 0 && sam_next[p][sym] == 0) begin
            sam_next[p][sym] = np;
            p = clip(sam_link[p]);
        end
        if (p == 0) begin
            sam_link[np] = 1;
        end else begin
            q = clip(sam_next[p][sym]);
            if (sam_len[q] == sam_len[p] + 1) begin
                sam_link[np] = q;
            end else begin
                sam_count++;
                nq = sam_count;
                sam_next[nq] = sam_next[q];
                sam_link[nq] = sam_link[q];
                sam_len[nq] = sam_len[p] + 1;
                sam_link[q] = nq;
                sam_link[np] = nq;
                while (p != 0 && sam_next[p][sym] == q) begin
                    sam_next[p][sym] = nq;
                    p = clip(sam_link[p]);
                end
            end
        end
        r.new_state = np[sab_pkg::SW-1:0];
        r.new_length = sam_len[np][sab_pkg::SW-1:0];
        r.new_link = sam_link[np][sab_pkg::SW-1:0];
        r.clone_state = nq[sab_pkg::SW-1:0];
        r.used_states = sam_count[sab_pkg::SW-1:0];
        return r;
    endfunction

    // Driver: the prediction is made when the transaction is accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(extend_automaton(s_tdata[4:0]));
                symbols_sent++;
            end
            if ((!s_tvalid || s_tready)) begin
                if (symbol_queue.size() > 0 && !hold_sender &&
                    (quiet_idle || $urandom_range(99) >= 6)) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {3'b000, symbol_queue.pop_front()};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sam_result_t got, exp_r;
                got = {m_tdata[10:0], m_tdata[21:11], m_tdata[32:22], m_tdata[43:33],
                       m_tdata[54:44], m_tuser};
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction %h", got);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.new_state !== exp_r.new_state) begin
                        $error("new_state exp %0d got %0d", exp_r.new_state, got.new_state);
                        error_count++;
                    end
                    if (got.new_length !== exp_r.new_length) begin
                        $error("new_length exp %0d got %0d", exp_r.new_length, got.new_length);
                        error_count++;
                    end
                    if (got.new_link !== exp_r.new_link) begin
                        $error("new_link exp %0d got %0d", exp_r.new_link, got.new_link);
                        error_count++;
                    end
                    if (got.clone_state !== exp_r.clone_state) begin
                        $error("clone_state exp %0d got %0d", exp_r.clone_state,
                               got.clone_state);
                        error_count++;
                    end
                    if (got.used_states !== exp_r.used_states) begin
                        $error("used_states exp %0d got %0d", exp_r.used_states,
                               got.used_states);
                        error_count++;
                    end
                    if (got.full !== exp_r.full) begin
                        $error("full_res exp %0d got %0d", exp_r.full, got.full);
                        error_count++;
                    end
                    if (exp_r.clone_state != 0) clones_seen++;
                    if (exp_r.full) full_seen++;
                end
            end
            m_tready <= quiet_idle || $urandom_range(99) >= 6;
        end
    end

    task automatic wait_drained();
        while (symbol_queue.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        logic [4:0] sym;
        int unsigned k;
        foreach (sam_len[i]) begin
            sam_len[i] = 0;
            sam_link[i] = 0;
        end
        foreach (sam_next[i, j]) sam_next[i][j] = 0;
        sam_last = 1;
        sam_count = 1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: alphabet ends, out-of-range symbols, repeats that force clones.
        symbol_queue = '{5'd0, 5'd25, 5'd26, 5'd31, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd1,
                         5'd1, 5'd0, 5'd25, 5'd25, 5'd0, 5'd1, 5'd2, 5'd0, 5'd1, 5'd3};
        wait_drained();

        // Sender held back once everything has drained, then a clean stretch.
        hold_sender = 1'b1;
        repeat (20) @(posedge aclk);
        hold_sender = 1'b0;
        quiet_idle = 1'b1;
        repeat (120) symbol_queue.push_back(5'($urandom_range(2)));
        wait_drained();
        quiet_idle = 1'b0;

        // Mostly small alphabets so that clones are frequent, some noise.
        for (k = 0; k < 510; k++) begin
            case ($urandom_range(9)) inside
                0: sym = 5'($urandom_range(31));
                1, 2: sym = 5'($urandom_range(25));
                default: sym = 5'($urandom_range(3));
            endcase
            symbol_queue.push_back(sym);
        end
        wait_drained();
        repeat (200) @(posedge aclk);

        $display("Sent %0d symbols, checked %0d results (%0d clones, %0d at capacity).",
                 symbols_sent, results_seen, clones_seen, full_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
